// ===== hdl/coo_sparse_dense_matmul_accumulate_defines.svh =====
// ---------------------------------------------------------------------------
// COO sparse-dense matmul accumulate: assertion macros
// Shared property wrappers clocked on aclk, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef COO_SPARSE_DENSE_MATMUL_ACCUMULATE_DEFINES_SVH
`define COO_SPARSE_DENSE_MATMUL_ACCUMULATE_DEFINES_SVH

// Check a property outside reset.
`define CSDMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property at every edge, reset included.
`define CSDMA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/csdma_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// COO sparse-dense matmul accumulate: shared package
// Operation codes, field widths and controller/datapath interface types.
// ---------------------------------------------------------------------------
package csdma_pkg;

    localparam int OP_W   = 2;
    localparam int IDX_W  = 8;
    localparam int LANE_W = 4;
    localparam int VAL_W  = 16;
    localparam int ACC_W  = 32;
    localparam int KCFG_W = 5;

    localparam logic [OP_W-1:0] OP_LOAD_X = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR_Y = 2'd1;
    localparam logic [OP_W-1:0] OP_ACCUM = 2'd2;
    localparam logic [OP_W-1:0] OP_READ_Y = 2'd3;

    localparam logic [KCFG_W-1:0] K_WIDTH_RESET = 5'd16;

    localparam logic [ACC_W-1:0] ACC_MAX = 32'h7FFF_FFFF;
    localparam logic [ACC_W-1:0] ACC_MIN = 32'h8000_0000;

    typedef logic [KCFG_W-1:0] kcnt_t;

    // Controller to datapath
    typedef struct packed {
        logic  capture;    // latch the accepted item
        logic  x_we;       // write X at item col/lane
        logic  y_clr;      // zero Y at item row, lane cnt
        logic  acc_issue;  // read X and Y for lane cnt into the MAC pipe
        logic  y_rd;       // read Y at item row/lane
        logic  out_load;   // load the result register
        kcnt_t cnt;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        kcnt_t           k_lanes;
        logic            row_ok;
        logic            col_ok;
        logic            lane_ok;
        logic            pipe_busy;
    } status_t;

endpackage

// ===== hdl/csdma_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// COO sparse-dense matmul accumulate: datapath
// X and Y stores, item registers, lane MAC pipeline and result register.
// ---------------------------------------------------------------------------
module csdma_datapath #(
    parameter int Y_ROWS = 256,
    parameter int X_ROWS = 256,
    parameter int K_MAX  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [csdma_pkg::KCFG_W-1:0]        cfg_wr_data,
    input  logic [csdma_pkg::OP_W-1:0]          in_op,
    input  logic [csdma_pkg::IDX_W-1:0]         in_row,
    input  logic [csdma_pkg::IDX_W-1:0]         in_col,
    input  logic [csdma_pkg::LANE_W-1:0]        in_lane,
    input  logic signed [csdma_pkg::VAL_W-1:0]  in_value,
    input  csdma_pkg::cmd_t                     cmd,
    output csdma_pkg::status_t                  status,
    output logic [csdma_pkg::ACC_W-1:0]         read_data,
    output logic                                saturated,
    output logic                                lane_error
);

    localparam int LANE_AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int XROW_AW = $clog2(X_ROWS);
    localparam int YROW_AW = $clog2(Y_ROWS);
    localparam int X_AW    = XROW_AW + LANE_AW;
    localparam int Y_AW    = YROW_AW + LANE_AW;
    localparam int X_DEPTH = 2 ** X_AW;
    localparam int Y_DEPTH = 2 ** Y_AW;
    localparam logic [31:0] X_ROWS_L = 32'(X_ROWS);
    localparam logic [31:0] Y_ROWS_L = 32'(Y_ROWS);
    localparam logic [31:0] K_MAX_L  = 32'(K_MAX);

    logic signed [csdma_pkg::VAL_W-1:0] x_mem [X_DEPTH];
    logic signed [csdma_pkg::ACC_W-1:0] y_mem [Y_DEPTH];

    logic [csdma_pkg::KCFG_W-1:0]       k_width_reg;
    logic [csdma_pkg::OP_W-1:0]         op_reg;
    logic [csdma_pkg::IDX_W-1:0]        row_reg;
    logic [csdma_pkg::IDX_W-1:0]        col_reg;
    logic [csdma_pkg::LANE_W-1:0]       lane_reg;
    logic signed [csdma_pkg::VAL_W-1:0] value_reg;

    logic signed [csdma_pkg::VAL_W-1:0] x_rd_reg;
    logic signed [csdma_pkg::ACC_W-1:0] y_rd_reg;
    logic                               s1_valid_reg;
    logic [LANE_AW-1:0]                 s1_lane_reg;
    logic                               s2_valid_reg;
    logic [LANE_AW-1:0]                 s2_lane_reg;
    logic signed [csdma_pkg::ACC_W-1:0] s2_prod_reg;
    logic signed [csdma_pkg::ACC_W-1:0] s2_yold_reg;
    logic                               sat_flag_reg;

    logic [csdma_pkg::ACC_W-1:0]        read_data_reg;
    logic                               saturated_reg;
    logic                               lane_error_reg;

    csdma_pkg::kcnt_t                   k_lanes;
    logic                               row_ok;
    logic                               col_ok;
    logic                               lane_ok;
    logic [YROW_AW-1:0]                 row_idx;
    logic [XROW_AW-1:0]                 col_idx;
    logic [LANE_AW-1:0]                 item_lane_idx;
    logic [LANE_AW-1:0]                 cnt_lane_idx;
    logic signed [csdma_pkg::ACC_W-1:0] prod;
    logic signed [csdma_pkg::ACC_W:0]   sum;
    logic                               sum_ovf;
    logic [csdma_pkg::ACC_W-1:0]        sum_sat;
    logic                               y_we;
    logic [Y_AW-1:0]                    y_waddr;
    logic [csdma_pkg::ACC_W-1:0]        y_wdata;
    logic                               y_re;
    logic [Y_AW-1:0]                    y_raddr;

    // Item decode
    always_comb begin
        k_lanes = (32'(k_width_reg) > K_MAX_L) ? csdma_pkg::KCFG_W'(K_MAX_L) : k_width_reg;
        row_ok  = 32'(row_reg) < Y_ROWS_L;
        col_ok  = 32'(col_reg) < X_ROWS_L;
        lane_ok = csdma_pkg::kcnt_t'(lane_reg) < k_lanes;
        row_idx = YROW_AW'(row_reg);
        col_idx = XROW_AW'(col_reg);
        item_lane_idx = LANE_AW'(lane_reg);
        cnt_lane_idx  = LANE_AW'(cmd.cnt);
    end

    assign status.op        = op_reg;
    assign status.k_lanes   = k_lanes;
    assign status.row_ok    = row_ok;
    assign status.col_ok    = col_ok;
    assign status.lane_ok   = lane_ok;
    assign status.pipe_busy = s1_valid_reg | s2_valid_reg;

    // Configuration and item registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_width_reg <= csdma_pkg::K_WIDTH_RESET;
        end else if (cfg_wr_en) begin
            k_width_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= in_op;
            row_reg   <= in_row;
            col_reg   <= in_col;
            lane_reg  <= in_lane;
            value_reg <= in_value;
        end
    end

    // X store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (cmd.x_we) begin
            x_mem[{col_idx, item_lane_idx}] <= value_reg;
        end
        if (cmd.acc_issue) begin
            x_rd_reg <= x_mem[{col_idx, cnt_lane_idx}];
        end
    end

    // Multiply-accumulate with saturation
    always_comb begin
        prod    = 32'(x_rd_reg) * 32'(value_reg);
        sum     = 33'(s2_yold_reg) + 33'(s2_prod_reg);
        sum_ovf = sum[csdma_pkg::ACC_W] != sum[csdma_pkg::ACC_W-1];
        if (!sum_ovf) begin
            sum_sat = sum[csdma_pkg::ACC_W-1:0];
        end else if (sum[csdma_pkg::ACC_W]) begin
            sum_sat = csdma_pkg::ACC_MIN;
        end else begin
            sum_sat = csdma_pkg::ACC_MAX;
        end
    end

    // Y port selection: clear and write-back never overlap
    always_comb begin
        y_we    = cmd.y_clr | s2_valid_reg;
        y_waddr = cmd.y_clr ? {row_idx, cnt_lane_idx} : {row_idx, s2_lane_reg};
        y_wdata = cmd.y_clr ? '0 : sum_sat;
        y_re    = cmd.acc_issue | cmd.y_rd;
        y_raddr = cmd.acc_issue ? {row_idx, cnt_lane_idx} : {row_idx, item_lane_idx};
    end

    always_ff @(posedge aclk) begin
        if (y_we) begin
            y_mem[y_waddr] <= y_wdata;
        end
        if (y_re) begin
            y_rd_reg <= y_mem[y_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.acc_issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_lane_reg <= cnt_lane_idx;
        s2_lane_reg <= s1_lane_reg;
        s2_prod_reg <= prod;
        s2_yold_reg <= y_rd_reg;
        if (cmd.capture) begin
            sat_flag_reg <= 1'b0;
        end else if (s2_valid_reg && sum_ovf) begin
            sat_flag_reg <= 1'b1;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            read_data_reg <= (op_reg == csdma_pkg::OP_READ_Y && lane_ok && row_ok)
                           ? y_rd_reg : '0;
            saturated_reg <= (op_reg == csdma_pkg::OP_ACCUM) && sat_flag_reg;
            lane_error_reg <= (op_reg == csdma_pkg::OP_LOAD_X
                            || op_reg == csdma_pkg::OP_READ_Y) && !lane_ok;
        end
    end

    assign read_data  = read_data_reg;
    assign saturated  = saturated_reg;
    assign lane_error = lane_error_reg;

endmodule

// ===== hdl/csdma_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// COO sparse-dense matmul accumulate: controller
// Sequences one item at a time and owns both stream handshakes.
// ---------------------------------------------------------------------------
module csdma_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  csdma_pkg::status_t status,
    output csdma_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_DISPATCH  = 3'd1;
    localparam logic [2:0] ST_CLEAR     = 3'd2;
    localparam logic [2:0] ST_ACC_ISSUE = 3'd3;
    localparam logic [2:0] ST_ACC_DRAIN = 3'd4;
    localparam logic [2:0] ST_READ_WAIT = 3'd5;
    localparam logic [2:0] ST_DONE      = 3'd6;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    csdma_pkg::kcnt_t cnt_reg;
    csdma_pkg::kcnt_t cnt_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic             last_lane;
    logic             out_free;

    assign last_lane = cnt_reg == (status.k_lanes - csdma_pkg::kcnt_t'(1));
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.cnt       = cnt_reg;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                cnt_next   = '0;
                state_next = ST_DONE;
                case (status.op)
                    csdma_pkg::OP_LOAD_X: begin
                        cmd.x_we = status.lane_ok && status.col_ok;
                    end
                    csdma_pkg::OP_CLEAR_Y: begin
                        if (status.row_ok && status.k_lanes != '0) begin
                            state_next = ST_CLEAR;
                        end
                    end
                    csdma_pkg::OP_ACCUM: begin
                        if (status.row_ok && status.col_ok && status.k_lanes != '0) begin
                            state_next = ST_ACC_ISSUE;
                        end
                    end
                    csdma_pkg::OP_READ_Y: begin
                        if (status.lane_ok && status.row_ok) begin
                            cmd.y_rd   = 1'b1;
                            state_next = ST_READ_WAIT;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_CLEAR: begin
                cmd.y_clr = 1'b1;
                cnt_next  = cnt_reg + csdma_pkg::kcnt_t'(1);
                if (last_lane) begin
                    state_next = ST_DONE;
                end
            end
            ST_ACC_ISSUE: begin
                cmd.acc_issue = 1'b1;
                cnt_next      = cnt_reg + csdma_pkg::kcnt_t'(1);
                if (last_lane) begin
                    state_next = ST_ACC_DRAIN;
                end
            end
            ST_ACC_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_READ_WAIT: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== hdl/coo_sparse_dense_matmul_accumulate.sv =====
`timescale 1ns / 1ps
// From accept to m_tvalid an item goes through dispatch, any clear, accumulate or read states, then done.
// One item at a time: a new item is taken only once the last one has been handed to the output register.
// Accumulate time is set by the lane MAC pipeline: one Y read-modify-write per lane per cycle.
// A finished result waits in the output register while the next item is taken.
// Reset (aresetn low, synchronous): controller idle, no result pending, k_width back to 16.
// X and Y stores are not cleared; Y rows must be cleared before they are accumulated.
// ---------------------------------------------------------------------------
// COO sparse-dense matmul accumulate: top level
// Sparse nonzero times dense X row, accumulated into a Q16.16 Y row store.
// ---------------------------------------------------------------------------
module coo_sparse_dense_matmul_accumulate #(
    parameter int Y_ROWS = 256,
    parameter int X_ROWS = 256,
    parameter int K_MAX  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Lane count register
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,   // k_width
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // row[7:0], col[15:8], lane[19:16], value[35:20], zero pad
    input  logic [1:0]  s_tuser,       // operation[1:0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // read_data[31:0]
    output logic [1:0]  m_tuser        // saturated[0], lane_error[1]
);

    csdma_pkg::cmd_t    cmd;
    csdma_pkg::status_t status;
    logic               saturated;
    logic               lane_error;

    // Sequence each item: dispatch on the opcode, step lanes, then hand the
    // result to the output register once it is free.
    csdma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the stores, the three-stage lane MAC (read, multiply, add and
    // write back) and the result payload.
    csdma_datapath #(
        .Y_ROWS (Y_ROWS),
        .X_ROWS (X_ROWS),
        .K_MAX  (K_MAX)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_op       (s_tuser),
        .in_row      (s_tdata[7:0]),
        .in_col      (s_tdata[15:8]),
        .in_lane     (s_tdata[19:16]),
        .in_value    (s_tdata[35:20]),
        .cmd         (cmd),
        .status      (status),
        .read_data   (m_tdata),
        .saturated   (saturated),
        .lane_error  (lane_error)
    );

    // Pad bits s_tdata[39:36] carry nothing and are dropped.
    assign m_tuser = {lane_error, saturated};

endmodule

// ===== hdl/csdma_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// COO sparse-dense matmul accumulate: port checker
// Watches the stream ports of the top level over time; bound to it below.
// ---------------------------------------------------------------------------
`include "coo_sparse_dense_matmul_accumulate_defines.svh"

module csdma_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `CSDMA_ASSERT(a_result_held, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `CSDMA_ASSERT(a_one_item, s_tvalid && s_tready |=> !s_tready, "second item taken during work")
    `CSDMA_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result pending after reset")
    `CSDMA_ASSERT(a_flags_excl, m_tvalid |-> !(m_tuser[0] && m_tuser[1]), "both flags set")
    `CSDMA_ASSERT(a_flag_no_data, m_tvalid && (m_tuser[0] || m_tuser[1]) |-> m_tdata == 32'd0, "data with flag")

endmodule

bind coo_sparse_dense_matmul_accumulate csdma_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
